/* rtl/core/double_ended_queue_top_defines.svh */
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dq_pkg.sv */
// Shared types, codes and defaults for the double-ended queue.
package dq_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the stream beats
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;

    // in beat: op, value; padded to whole bytes
    localparam int IN_BITS  = OP_W + VALUE_W;
    localparam int IN_TDW   = ((IN_BITS + 7) / 8) * 8;
    // out beat: popped, front, back, count, is_empty, error
    localparam int OUT_BITS = 3 * VALUE_W + COUNT_W + 1 + ERR_W;
    localparam int OUT_TDW  = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_LOAD_TAIL,
        CELL_DROP_TAIL
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
    } t_cell_ctrl;

endpackage

/* rtl/core/dq_cell.sv */
// One storage cell of the deque chain: a word and its occupied flag.
module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dq_pkg::t_cell_ctrl    i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_word,       // word being pushed at the back
    input  logic                  i_left_vld,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_right_vld,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    output logic                  o_vld,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic                  r_vld;
    logic                  n_vld;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // next contents from the broadcast command and the two neighbors
    always_comb begin
        n_vld  = r_vld;
        n_data = r_data;
        unique case (i_ctrl.cmd)
            dq_pkg::CELL_SHIFT_RIGHT: begin
                n_vld  = i_left_vld;
                n_data = i_left_data;
            end
            dq_pkg::CELL_SHIFT_LEFT: begin
                n_vld  = i_right_vld;
                n_data = i_right_data;
            end
            dq_pkg::CELL_LOAD_TAIL: begin
                // first free cell after the occupied run takes the word
                if (!r_vld && i_left_vld) begin
                    n_vld  = 1'b1;
                    n_data = i_word;
                end
            end
            dq_pkg::CELL_DROP_TAIL: begin
                // last occupied cell lets go of its word
                if (r_vld && !i_right_vld) begin
                    n_vld = 1'b0;
                end
            end
            default: begin
                n_vld  = r_vld;
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* rtl/core/double_ended_queue_top.sv */
// Double-ended queue built as a shifting chain of cells, front at cell zero.
//
// Usage: each beat on the s-side carries one operation (push front, push back,
// pop front, pop back) and a word; every accepted beat yields exactly one
// m-side beat with the popped word, the new front and back words, the count,
// an empty flag and an error code. Pop on empty and push on full are flagged
// and leave the contents unchanged.
// Latency: the result beat is valid the cycle after the operation beat is
// accepted. Throughput: one operation per cycle unless a result waits; the
// chain updates with the output, and the back word is taken from the last cell.
// The output register is the only buffer: while a result waits unaccepted,
// s_tready is low, and it rises in the same cycle the result is taken.
// Reset (synchronous, active low) empties the chain and drops any pending
// result; stored words themselves are not cleared.
// Words are kept at DATA_WIDTH bits, returned sign-extended or cut to 32 bits.
// The reported count is the low 5 bits of the true count.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dq_pkg::IN_TDW-1:0]  s_tdata,   // op[1:0], value[33:2], zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dq_pkg::OUT_TDW-1:0] m_tdata    // popped[31:0], front[63:32],
                                                  // back[95:64], count[100:96],
                                                  // is_empty[101], error[103:102]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = dq_pkg::VALUE_W;

    // input beat fields
    logic [dq_pkg::OP_W-1:0] w_op;
    logic [VW-1:0]           w_value;
    logic [DATA_WIDTH-1:0]   w_word;
    logic                    w_in_acc;

    assign w_op     = s_tdata[dq_pkg::OP_W-1:0];
    assign w_value  = s_tdata[dq_pkg::OP_W +: VW];
    assign w_in_acc = s_tvalid && s_tready;

    // keep the low DATA_WIDTH bits of the value, zero-extended if wider
    generate
        if (DATA_WIDTH <= VW) begin : g_word_narrow
            assign w_word = w_value[DATA_WIDTH-1:0];
        end else begin : g_word_wide
            assign w_word = {{(DATA_WIDTH - VW){1'b0}}, w_value};
        end
    endgenerate

    // occupancy
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_empty;
    logic             w_full;
    logic             w_one;

    assign w_empty = (r_cnt == '0);
    assign w_full  = (r_cnt == CNT_W'(DEPTH));
    assign w_one   = (r_cnt == CNT_W'(1));

    // cell chain
    dq_pkg::t_cell_ctrl    w_ctrl;
    logic [DEPTH+1:0]      w_vld;     // two spare zeros beyond the last cell
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_last;
    logic [DEPTH-1:0]      w_prev_last;

    assign w_vld[DEPTH+1:DEPTH] = 2'b00;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                  w_lv;
            logic [DATA_WIDTH-1:0] w_ld;
            logic [DATA_WIDTH-1:0] w_rd;

            if (gi == 0) begin : g_head
                // head takes the pushed word on a front push
                assign w_lv = 1'b1;
                assign w_ld = w_word;
            end else begin : g_body
                assign w_lv = w_vld[gi-1];
                assign w_ld = w_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_rd = '0;
            end else begin : g_inner
                assign w_rd = w_data[gi+1];
            end

            dq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_word       (w_word),
                .i_left_vld   (w_lv),
                .i_left_data  (w_ld),
                .i_right_vld  (w_vld[gi+1]),
                .i_right_data (w_rd),
                .o_vld        (w_vld[gi]),
                .o_data       (w_data[gi])
            );

            // last occupied cell, and the one just before it
            assign w_last[gi]      = w_vld[gi] && !w_vld[gi+1];
            assign w_prev_last[gi] = w_vld[gi+1] && !w_vld[gi+2];
        end
    endgenerate

    // back word and the word before it, via one-hot select
    logic [DATA_WIDTH-1:0] w_back_cur;
    logic [DATA_WIDTH-1:0] w_back_prev;

    always_comb begin
        w_back_cur  = '0;
        w_back_prev = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_cur  = w_back_cur  | (w_data[k] & {DATA_WIDTH{w_last[k]}});
            w_back_prev = w_back_prev | (w_data[k] & {DATA_WIDTH{w_prev_last[k]}});
        end
    end

    // operation decode and result words
    logic [dq_pkg::ERR_W-1:0] w_err;
    logic [DATA_WIDTH-1:0]    w_popped;
    logic [DATA_WIDTH-1:0]    w_front;
    logic [DATA_WIDTH-1:0]    w_back;
    dq_pkg::t_cell_cmd        w_cmd;

    always_comb begin
        w_cmd    = dq_pkg::CELL_HOLD;
        w_err    = dq_pkg::ERR_NONE;
        w_popped = '0;
        w_front  = w_empty ? '0 : w_data[0];
        w_back   = w_empty ? '0 : w_back_cur;
        n_cnt    = r_cnt;
        unique case (w_op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_err = dq_pkg::ERR_PUSH_FULL;
                end else begin
                    w_cmd   = dq_pkg::CELL_SHIFT_RIGHT;
                    n_cnt   = r_cnt + CNT_W'(1);
                    w_front = w_word;
                    w_back  = w_empty ? w_word : w_back_cur;
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_err = dq_pkg::ERR_PUSH_FULL;
                end else begin
                    w_cmd   = dq_pkg::CELL_LOAD_TAIL;
                    n_cnt   = r_cnt + CNT_W'(1);
                    w_front = w_empty ? w_word : w_data[0];
                    w_back  = w_word;
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_err = dq_pkg::ERR_POP_EMPTY;
                end else begin
                    w_cmd    = dq_pkg::CELL_SHIFT_LEFT;
                    n_cnt    = r_cnt - CNT_W'(1);
                    w_popped = w_data[0];
                    w_front  = w_one ? '0 : w_data[1];
                    w_back   = w_one ? '0 : w_back_cur;
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_err = dq_pkg::ERR_POP_EMPTY;
                end else begin
                    w_cmd    = dq_pkg::CELL_DROP_TAIL;
                    n_cnt    = r_cnt - CNT_W'(1);
                    w_popped = w_back_cur;
                    w_front  = w_one ? '0 : w_data[0];
                    w_back   = w_one ? '0 : w_back_prev;
                end
            end
            default: begin
                w_cmd = dq_pkg::CELL_HOLD;
            end
        endcase
    end

    assign w_ctrl.cmd = w_in_acc ? w_cmd : dq_pkg::CELL_HOLD;

    // sign-extend or truncate stored words to the 32-bit output fields
    logic [VW-1:0] w_popped_x;
    logic [VW-1:0] w_front_x;
    logic [VW-1:0] w_back_x;

    generate
        if (DATA_WIDTH < VW) begin : g_sext
            assign w_popped_x = {{(VW - DATA_WIDTH){w_popped[DATA_WIDTH-1]}}, w_popped};
            assign w_front_x  = {{(VW - DATA_WIDTH){w_front[DATA_WIDTH-1]}}, w_front};
            assign w_back_x   = {{(VW - DATA_WIDTH){w_back[DATA_WIDTH-1]}}, w_back};
        end else begin : g_trunc
            assign w_popped_x = w_popped[VW-1:0];
            assign w_front_x  = w_front[VW-1:0];
            assign w_back_x   = w_back[VW-1:0];
        end
    endgenerate

    // count reported in its 5-bit field
    logic [dq_pkg::COUNT_W-1:0] w_count_x;

    generate
        if (CNT_W >= dq_pkg::COUNT_W) begin : g_cnt_trunc
            assign w_count_x = n_cnt[dq_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_x = {{(dq_pkg::COUNT_W - CNT_W){1'b0}}, n_cnt};
        end
    endgenerate

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc) begin
            r_cnt <= n_cnt;
        end
    end

    // output register
    logic                       r_out_vld;
    logic [dq_pkg::OUT_TDW-1:0] r_out_data;
    logic [dq_pkg::OUT_TDW-1:0] n_out_data;

    assign n_out_data = dq_pkg::OUT_TDW'({w_err, (n_cnt == '0), w_count_x,
                                          w_back_x, w_front_x, w_popped_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_tready = !r_out_vld || m_tready;
    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;

    // checks
    `DQ_ASSERT_NOW(a_cnt_matches_cells, i_clk, i_rst_n, 1'b1,
        $countones(w_vld) == int'(r_cnt), "count disagrees with occupied cells")
    `DQ_ASSERT_NOW(a_single_tail, i_clk, i_rst_n, 1'b1,
        $onehot0(w_last) && (w_vld[0] == !w_empty), "occupied cells not contiguous")
    `DQ_ASSERT_NEXT(a_pop_empty_flag, i_clk, i_rst_n,
        w_in_acc && w_empty && (w_op == dq_pkg::OP_POP_FRONT || w_op == dq_pkg::OP_POP_BACK),
        (r_cnt == '0) && (m_tdata[103:102] == dq_pkg::ERR_POP_EMPTY),
        "pop on empty not flagged")
    `DQ_ASSERT_NEXT(a_push_full_flag, i_clk, i_rst_n,
        w_in_acc && w_full && (w_op == dq_pkg::OP_PUSH_FRONT || w_op == dq_pkg::OP_PUSH_BACK),
        w_full && (m_tdata[103:102] == dq_pkg::ERR_PUSH_FULL),
        "push on full not flagged")

endmodule

/* bench/double_ended_queue_top_tb.sv */
// Self-checking testbench for the double-ended queue: random ops on both ends with stalls.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;

    localparam int QDEPTH    = dq_pkg::DEPTH_DEF;
    localparam int MAX_CYCLE = 1_000_000;
    localparam int N_RANDOM  = 1700;

    typedef struct {
        logic [dq_pkg::OP_W-1:0]    op;
        logic [dq_pkg::VALUE_W-1:0] word;
        bit                         drain_first;  // hold until every result is back
    } t_dq_cmd;

    typedef struct {
        logic [dq_pkg::VALUE_W-1:0] popped;
        logic [dq_pkg::VALUE_W-1:0] front;
        logic [dq_pkg::VALUE_W-1:0] back;
        logic [dq_pkg::COUNT_W-1:0] count;
        logic                       empty;
        logic [dq_pkg::ERR_W-1:0]   err;
    } t_dq_result;

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [dq_pkg::IN_TDW-1:0]  s_tdata  = '0;   // op[1:0], value[33:2], zero pad
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [dq_pkg::OUT_TDW-1:0] m_tdata;         // popped[31:0], front[63:32],
                                                 // back[95:64], count[100:96],
                                                 // is_empty[101], error[103:102]

    double_ended_queue_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow deque state
    logic [dq_pkg::VALUE_W-1:0] slot_mem [QDEPTH];
    int unsigned                head_idx  = 0;
    int unsigned                fill_cnt  = 0;

    t_dq_cmd    pending_ops [$];
    t_dq_result expected_results [$];

    int  n_errors   = 0;
    int  n_accepted = 0;
    int  n_results  = 0;
    int  cycles     = 0;
    bit  in_taken   = 1'b0;
    bit  hold_off   = 1'b0;
    bit  send_calm  = 1'b0;
    bit  recv_calm  = 1'b0;
    int  send_gap   = 0;
    int  recv_gap   = 0;

    // coverage tallies for the summary
    int  n_push_ok  = 0;
    int  n_pop_ok   = 0;
    int  n_full     = 0;
    int  n_empty    = 0;
    int  peak_fill  = 0;

    t_dq_cmd                   drv_cmd;
    logic [dq_pkg::IN_TDW-1:0] drv_beat;

    function automatic int unsigned tail_idx(int unsigned head, int unsigned fill);
        return (head + fill - 1) % QDEPTH;
    endfunction

    // apply one operation to the shadow state, return the result beat it yields
    function automatic t_dq_result apply_op(logic [dq_pkg::OP_W-1:0] op,
                                            logic [dq_pkg::VALUE_W-1:0] word);
        t_dq_result r;
        r.popped = '0;
        r.err    = dq_pkg::ERR_NONE;
        case (op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                if (fill_cnt >= QDEPTH) begin
                    r.err = dq_pkg::ERR_PUSH_FULL;
                    n_full++;
                end else if (op == dq_pkg::OP_PUSH_FRONT) begin
                    head_idx = (head_idx == 0) ? QDEPTH - 1 : head_idx - 1;
                    slot_mem[head_idx] = word;
                    fill_cnt++;
                    n_push_ok++;
                end else begin
                    fill_cnt++;
                    slot_mem[tail_idx(head_idx, fill_cnt)] = word;
                    n_push_ok++;
                end
            end
            default: begin
                if (fill_cnt == 0) begin
                    r.err = dq_pkg::ERR_POP_EMPTY;
                    n_empty++;
                end else if (op == dq_pkg::OP_POP_FRONT) begin
                    r.popped = slot_mem[head_idx];
                    head_idx = (head_idx + 1) % QDEPTH;
                    fill_cnt--;
                    n_pop_ok++;
                end else begin
                    r.popped = slot_mem[tail_idx(head_idx, fill_cnt)];
                    fill_cnt--;
                    n_pop_ok++;
                end
            end
        endcase
        if (fill_cnt == 0) begin
            r.front = '0;
            r.back  = '0;
        end else begin
            r.front = slot_mem[head_idx];
            r.back  = slot_mem[tail_idx(head_idx, fill_cnt)];
        end
        r.count = dq_pkg::COUNT_W'(fill_cnt);
        r.empty = (fill_cnt == 0);
        if (int'(fill_cnt) > peak_fill) peak_fill = int'(fill_cnt);
        return r;
    endfunction

    function automatic void check_field(string name, logic [dq_pkg::VALUE_W-1:0] want,
                                        logic [dq_pkg::VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [dq_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return dq_pkg::VALUE_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_cmd(logic [dq_pkg::OP_W-1:0] op,
                                    logic [dq_pkg::VALUE_W-1:0] word, bit drain_first);
        t_dq_cmd c;
        c.op          = op;
        c.word        = word;
        c.drain_first = drain_first;
        pending_ops.push_back(c);
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: check result beats, predict from accepted operation beats
    always @(posedge i_clk) begin : monitor
        t_dq_result want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no operation outstanding: %h", m_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("popped_value", want.popped, m_tdata[31:0]);
                    check_field("front_value", want.front, m_tdata[63:32]);
                    check_field("back_value", want.back, m_tdata[95:64]);
                    check_field("count", dq_pkg::VALUE_W'(want.count),
                                dq_pkg::VALUE_W'(m_tdata[100:96]));
                    check_field("is_empty", dq_pkg::VALUE_W'(want.empty),
                                dq_pkg::VALUE_W'(m_tdata[101]));
                    check_field("error", dq_pkg::VALUE_W'(want.err),
                                dq_pkg::VALUE_W'(m_tdata[103:102]));
                end
            end
            if (in_taken) begin
                n_accepted++;
                expected_results.push_back(apply_op(s_tdata[1:0], s_tdata[33:2]));
            end
        end
    end

    // driver: present operation beats with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].drain_first && expected_results.size() != 0)) begin
                drv_cmd  = pending_ops.pop_front();
                drv_beat = '0;
                drv_beat[1:0]  = drv_cmd.op;
                drv_beat[33:2] = drv_cmd.word;
                s_tdata  <= drv_beat;
                s_tvalid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            m_tready <= 1'b1;
            recv_gap = pick_gap(recv_calm);
        end
    end

    // long receiver hold-off once traffic is flowing, so the input backs up
    initial begin
        while (n_accepted < 400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : stimulus
        int seg_left;
        int push_pct;
        logic [dq_pkg::OP_W-1:0] op;

        // empty pops, extreme words at both ends, back to empty
        add_cmd(dq_pkg::OP_POP_FRONT, 32'h1234_5678, 1'b0);
        add_cmd(dq_pkg::OP_POP_BACK, 32'hffff_ffff, 1'b0);
        add_cmd(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0);   // front index wraps below zero
        add_cmd(dq_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 1'b0);
        add_cmd(dq_pkg::OP_POP_BACK, 32'h0, 1'b0);
        add_cmd(dq_pkg::OP_POP_FRONT, 32'h0, 1'b0);
        add_cmd(dq_pkg::OP_POP_FRONT, 32'h0, 1'b0);
        // fill to capacity from both ends, then push on full
        for (int i = 0; i < QDEPTH; i++) begin
            case (i % 4)
                0: add_cmd(dq_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
                1: add_cmd(dq_pkg::OP_PUSH_BACK, 32'h8000_0000, 1'b0);
                2: add_cmd(dq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
                default: add_cmd(dq_pkg::OP_PUSH_BACK, dq_pkg::VALUE_W'(i), 1'b0);
            endcase
        end
        add_cmd(dq_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0);
        add_cmd(dq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa, 1'b0);

        // random part in segments biased toward filling, draining or neither
        seg_left = 0;
        push_pct = 50;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
            add_cmd(op, pick_word(), i == 900);
        end

        // reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for all beats to go in and all results to come out
        while (pending_ops.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d operations, %0d results: %0d pushes, %0d pops, peak fill %0d",
                 n_accepted, n_results, n_push_ok, n_pop_ok, peak_fill);
        $display("flagged %0d pushes on full and %0d pops on empty", n_full, n_empty);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
